// ===== design/spf_pkg.sv =====
// Shared types and constants for the spectrum peak / FWHM estimator.
// No dependencies; used by spf_alu and the top level of the block.
package spf_pkg;

  typedef enum logic [1:0] {
    ALU_ADD,
    ALU_SUB_SAT,
    ALU_ADD_SAT
  } alu_op_t;

  typedef logic [1:0] status_t;

  localparam status_t ST_OK    = 2'd0;
  localparam status_t ST_RANGE = 2'd1;
  localparam status_t ST_OVF   = 2'd2;

  localparam logic REG_START = 1'b0;
  localparam logic REG_END   = 1'b1;

endpackage

// ===== design/spf_if.sv =====
// Valid/ready channel interfaces for sample words in and result words out.
// Depends on nothing but its own parameters.
interface spf_in_if #(
  parameter int COUNT_BITS = 32
);
  logic                  valid;
  logic                  ready;
  logic [COUNT_BITS-1:0] sample_count;
  logic                  is_last;

  modport source (output valid, sample_count, is_last, input ready);
  modport sink   (input valid, sample_count, is_last, output ready);
endinterface

interface spf_out_if #(
  parameter int CH_W       = 12,
  parameter int CNT_W      = 13,
  parameter int COUNT_BITS = 32
);
  logic                  valid;
  logic                  ready;
  logic [CH_W-1:0]       peak_channel;
  logic [COUNT_BITS-1:0] peak_height;
  logic [CNT_W-1:0]      peak_width;
  logic [CNT_W-1:0]      window_low;
  logic [CNT_W-1:0]      window_high;
  logic                  window_clipped;
  logic [1:0]            status;

  modport source (output valid, peak_channel, peak_height, peak_width, window_low,
                  window_high, window_clipped, status, input ready);
  modport sink   (input valid, peak_channel, peak_height, peak_width, window_low,
                  window_high, window_clipped, status, output ready);
endinterface

// ===== design/spf_store.sv =====
// Sample store: one write port, one read port with registered read data.
// No package dependency.
module spf_store #(
  parameter int DEPTH = 4096,
  parameter int AW    = 12,
  parameter int DW    = 32
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [DW-1:0] wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr,
  output logic [DW-1:0] rdata
);

  logic [DW-1:0] mem [DEPTH];
  logic [DW-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== design/spf_alu.sv =====
// Shared add/subtract unit with saturation at zero or at a limit.
// Depends on spf_pkg for the operation codes.
module spf_alu #(
  parameter int WW  = 16,
  parameter int LW  = 13
) (
  input  spf_pkg::alu_op_t op,
  input  logic [WW-1:0]    a,
  input  logic [WW-1:0]    b,
  input  logic             cin,
  input  logic [LW-1:0]    lim,
  output logic [WW-1:0]    res,
  output logic             clip
);

  logic [WW:0] sum;
  logic [WW:0] diff;

  assign sum  = {1'b0, a} + {1'b0, b} + {{WW{1'b0}}, cin};
  assign diff = {1'b0, a} - {1'b0, b};

  always_comb begin
    res  = sum[WW-1:0];
    clip = 1'b0;
    case (op)
      spf_pkg::ALU_ADD: begin
        res = sum[WW-1:0];
      end
      spf_pkg::ALU_SUB_SAT: begin
        if (diff[WW]) begin
          res  = '0;
          clip = 1'b1;
        end else begin
          res = diff[WW-1:0];
        end
      end
      spf_pkg::ALU_ADD_SAT: begin
        if (sum > (WW+1)'(lim)) begin
          res  = WW'(lim);
          clip = 1'b1;
        end else begin
          res = sum[WW-1:0];
        end
      end
      default: begin
        res = sum[WW-1:0];
      end
    endcase
  end

endmodule

// ===== design/spectrum_peak_fwhm_estimator.sv =====
// Spectrum peak and half-maximum width estimator, top level.
// Depends on spf_pkg, spf_if, spf_store and spf_alu.
//
// Samples are taken one word per cycle into the store; ready stays high while loading.
// After the word flagged is_last the block drops ready and works through the spectrum
// on its store: the maximum search from search_start up to search_end, a half-maximum
// walk channel by channel, with a stop test, to the left and then to the right of the
// peak, the width and fit window on the shared add/subtract unit, and the hand-over of
// the result; an invalid range or overflow reports straight away. The result word sits
// in an output register, so loading of the next spectrum may begin while it waits.
module spectrum_peak_fwhm_estimator #(
  parameter int MAX_CHANNELS = 4096,
  parameter int COUNT_BITS   = 32
) (
  input  logic              clk,
  input  logic              rst_n,
  spf_in_if.sink            in_ch,
  spf_out_if.source         out_ch,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [2:0]        paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  localparam int CH_W  = $clog2(MAX_CHANNELS);
  localparam int CNT_W = $clog2(MAX_CHANNELS + 1);
  localparam int WW    = CNT_W + 3;
  localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_CHANNELS);

  typedef enum logic [5:0] {
    S_LOAD  = 6'b000001,
    S_SRCH  = 6'b000010,
    S_WALKL = 6'b000100,
    S_WALKR = 6'b001000,
    S_CALC  = 6'b010000,
    S_FIN   = 6'b100000
  } state_t;

  typedef enum logic [9:0] {
    C_HL = 10'b0000000001,
    C_HR = 10'b0000000010,
    C_WD = 10'b0000000100,
    C_TL = 10'b0000001000,
    C_CL = 10'b0000010000,
    C_TR = 10'b0000100000,
    C_CH = 10'b0001000000,
    C_D  = 10'b0010000000,
    C_WL = 10'b0100000000,
    C_WH = 10'b1000000000
  } calc_step_t;

  // configuration
  logic [CH_W-1:0]  start_r;
  logic [CNT_W-1:0] end_r;
  logic             cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_r <= '0;
      end_r   <= MAX_CNT;
    end else if (cfg_wr) begin
      if (paddr[2] == spf_pkg::REG_START) begin
        start_r <= pwdata[CH_W-1:0];
      end else begin
        end_r <= pwdata[CNT_W-1:0];
      end
    end
  end

  always_comb begin
    if (paddr[2] == spf_pkg::REG_START) begin
      prdata = 32'(start_r);
    end else begin
      prdata = 32'(end_r);
    end
  end

  // control and datapath registers
  state_t               state_r, state_nxt;
  calc_step_t           step_r, step_nxt;
  logic [CNT_W-1:0]     load_cnt_r, load_cnt_nxt;
  logic                 ovf_r, ovf_nxt;
  logic [CNT_W-1:0]     n_r, n_nxt;
  spf_pkg::status_t     stat_r, stat_nxt;
  logic [CNT_W-1:0]     addr_r, addr_nxt;
  logic                 pend_r, pend_nxt;
  logic [CH_W-1:0]      pidx_r, pidx_nxt;
  logic                 first_r, first_nxt;
  logic                 ph_r, ph_nxt;
  logic [COUNT_BITS-1:0] height_r, height_nxt;
  logic [CH_W-1:0]      peak_r, peak_nxt;
  logic [CH_W-1:0]      left_r, left_nxt;
  logic [CH_W-1:0]      right_r, right_nxt;
  logic [CH_W-1:0]      hl_r, hl_nxt;
  logic [CH_W-1:0]      hr_r, hr_nxt;
  logic [CNT_W-1:0]     width_r, width_nxt;
  logic [WW-1:0]        tmp_r, tmp_nxt;
  logic [CNT_W-1:0]     core_lo_r, core_lo_nxt;
  logic [CNT_W-1:0]     core_hi_r, core_hi_nxt;
  logic [CNT_W-1:0]     d_r, d_nxt;
  logic [CNT_W-1:0]     win_lo_r, win_lo_nxt;
  logic [CNT_W-1:0]     win_hi_r, win_hi_nxt;
  logic                 clip_r, clip_nxt;
  logic                 out_vld_r, out_vld_nxt;

  // store
  logic                  in_acc, full, st_we, st_re;
  logic [CH_W-1:0]       st_raddr;
  logic [COUNT_BITS-1:0] st_rdata;
  logic [CNT_W-1:0]      n_new;
  logic                  srch_issue;
  logic [COUNT_BITS-1:0] half;
  logic                  above_half;

  assign in_ch.ready = (state_r == S_LOAD);
  assign in_acc      = in_ch.valid & in_ch.ready;
  assign full        = (load_cnt_r == MAX_CNT);
  assign st_we       = in_acc & ~full;
  assign n_new       = full ? load_cnt_r : load_cnt_r + CNT_W'(1);
  assign srch_issue  = (state_r == S_SRCH) && (addr_r < end_r);
  assign half        = height_r >> 1;
  assign above_half  = st_rdata > half;

  always_comb begin
    st_re    = 1'b0;
    st_raddr = addr_r[CH_W-1:0];
    case (state_r)
      S_SRCH: begin
        st_re    = srch_issue;
        st_raddr = addr_r[CH_W-1:0];
      end
      S_WALKL: begin
        st_re    = ~ph_r;
        st_raddr = left_r;
      end
      S_WALKR: begin
        st_re    = ~ph_r;
        st_raddr = right_r;
      end
      default: begin
        st_re = 1'b0;
      end
    endcase
  end

  spf_store #(
    .DEPTH (MAX_CHANNELS),
    .AW    (CH_W),
    .DW    (COUNT_BITS)
  ) u_store (
    .clk   (clk),
    .we    (st_we),
    .waddr (load_cnt_r[CH_W-1:0]),
    .wdata (in_ch.sample_count),
    .re    (st_re),
    .raddr (st_raddr),
    .rdata (st_rdata)
  );

  // shared arithmetic unit
  spf_pkg::alu_op_t alu_op;
  logic [WW-1:0]    alu_a, alu_b, alu_res;
  logic             alu_cin, alu_clip;

  always_comb begin
    alu_op  = spf_pkg::ALU_ADD;
    alu_a   = WW'(peak_r);
    alu_b   = WW'(left_r);
    alu_cin = 1'b0;
    case (step_r)
      C_HL: begin
        alu_op = spf_pkg::ALU_SUB_SAT;
        alu_a  = WW'(peak_r);
        alu_b  = WW'(left_r);
      end
      C_HR: begin
        alu_op = spf_pkg::ALU_SUB_SAT;
        alu_a  = WW'(right_r);
        alu_b  = WW'(peak_r);
      end
      C_WD: begin
        alu_a   = WW'(hl_r);
        alu_b   = WW'(hr_r);
        alu_cin = 1'b1;
      end
      C_TL: begin
        alu_a = WW'(hl_r) << 2;
        alu_b = WW'(hl_r);
      end
      C_CL: begin
        alu_op = spf_pkg::ALU_SUB_SAT;
        alu_a  = WW'(peak_r);
        alu_b  = tmp_r >> 1;
      end
      C_TR: begin
        alu_a = WW'(hr_r) << 2;
        alu_b = WW'(hr_r);
      end
      C_CH: begin
        alu_op = spf_pkg::ALU_ADD_SAT;
        alu_a  = WW'(peak_r);
        alu_b  = tmp_r >> 1;
      end
      C_D: begin
        alu_op = spf_pkg::ALU_SUB_SAT;
        alu_a  = WW'(core_hi_r);
        alu_b  = WW'(core_lo_r);
      end
      C_WL: begin
        alu_op = spf_pkg::ALU_SUB_SAT;
        alu_a  = WW'(core_lo_r);
        alu_b  = WW'(d_r) << 1;
      end
      C_WH: begin
        alu_op = spf_pkg::ALU_ADD_SAT;
        alu_a  = WW'(core_hi_r);
        alu_b  = WW'(d_r) << 1;
      end
      default: begin
        alu_op = spf_pkg::ALU_ADD;
      end
    endcase
  end

  spf_alu #(
    .WW (WW),
    .LW (CNT_W)
  ) u_alu (
    .op   (alu_op),
    .a    (alu_a),
    .b    (alu_b),
    .cin  (alu_cin),
    .lim  (n_r),
    .res  (alu_res),
    .clip (alu_clip)
  );

  // sequencer
  always_comb begin
    state_nxt   = state_r;
    step_nxt    = step_r;
    load_cnt_nxt = load_cnt_r;
    ovf_nxt     = ovf_r;
    n_nxt       = n_r;
    stat_nxt    = stat_r;
    addr_nxt    = addr_r;
    pend_nxt    = 1'b0;
    pidx_nxt    = pidx_r;
    first_nxt   = first_r;
    ph_nxt      = ph_r;
    height_nxt  = height_r;
    peak_nxt    = peak_r;
    left_nxt    = left_r;
    right_nxt   = right_r;
    hl_nxt      = hl_r;
    hr_nxt      = hr_r;
    width_nxt   = width_r;
    tmp_nxt     = tmp_r;
    core_lo_nxt = core_lo_r;
    core_hi_nxt = core_hi_r;
    d_nxt       = d_r;
    win_lo_nxt  = win_lo_r;
    win_hi_nxt  = win_hi_r;
    clip_nxt    = clip_r;
    out_vld_nxt = out_vld_r & ~out_ch.ready;

    case (state_r)
      S_LOAD: begin
        if (in_acc) begin
          load_cnt_nxt = n_new;
          ovf_nxt      = ovf_r | full;
          if (in_ch.is_last) begin
            load_cnt_nxt = '0;
            ovf_nxt      = 1'b0;
            n_nxt        = n_new;
            addr_nxt     = CNT_W'(start_r);
            first_nxt    = 1'b1;
            clip_nxt     = 1'b0;
            if (ovf_r || full) begin
              stat_nxt  = spf_pkg::ST_OVF;
              state_nxt = S_FIN;
            end else if ((CNT_W'(start_r) >= end_r) || (end_r > n_new)) begin
              stat_nxt  = spf_pkg::ST_RANGE;
              state_nxt = S_FIN;
            end else begin
              stat_nxt  = spf_pkg::ST_OK;
              state_nxt = S_SRCH;
            end
          end
        end
      end
      S_SRCH: begin
        if (srch_issue) begin
          addr_nxt = addr_r + CNT_W'(1);
          pend_nxt = 1'b1;
          pidx_nxt = addr_r[CH_W-1:0];
        end
        if (pend_r) begin
          first_nxt = 1'b0;
          if (first_r || (st_rdata > height_r)) begin
            height_nxt = st_rdata;
            peak_nxt   = pidx_r;
          end
        end
        if (!srch_issue && !pend_r) begin
          left_nxt  = peak_r;
          ph_nxt    = 1'b0;
          state_nxt = S_WALKL;
        end
      end
      S_WALKL: begin
        ph_nxt = ~ph_r;
        if (ph_r) begin
          if ((left_r != '0) && above_half) begin
            left_nxt = left_r - CH_W'(1);
          end else begin
            right_nxt = peak_r;
            state_nxt = S_WALKR;
          end
        end
      end
      S_WALKR: begin
        ph_nxt = ~ph_r;
        if (ph_r) begin
          if ((CNT_W'(right_r) + CNT_W'(1) < n_r) && above_half) begin
            right_nxt = right_r + CH_W'(1);
          end else begin
            step_nxt  = C_HL;
            state_nxt = S_CALC;
          end
        end
      end
      S_CALC: begin
        case (step_r)
          C_HL: begin
            hl_nxt   = alu_res[CH_W-1:0];
            step_nxt = C_HR;
          end
          C_HR: begin
            hr_nxt   = alu_res[CH_W-1:0];
            step_nxt = C_WD;
          end
          C_WD: begin
            width_nxt = alu_res[CNT_W-1:0];
            step_nxt  = C_TL;
          end
          C_TL: begin
            tmp_nxt  = alu_res;
            step_nxt = C_CL;
          end
          C_CL: begin
            core_lo_nxt = alu_res[CNT_W-1:0];
            clip_nxt    = clip_r | alu_clip;
            step_nxt    = C_TR;
          end
          C_TR: begin
            tmp_nxt  = alu_res;
            step_nxt = C_CH;
          end
          C_CH: begin
            core_hi_nxt = alu_res[CNT_W-1:0];
            clip_nxt    = clip_r | alu_clip;
            step_nxt    = C_D;
          end
          C_D: begin
            d_nxt    = alu_res[CNT_W-1:0];
            step_nxt = C_WL;
          end
          C_WL: begin
            win_lo_nxt = alu_res[CNT_W-1:0];
            clip_nxt   = clip_r | alu_clip;
            step_nxt   = C_WH;
          end
          C_WH: begin
            win_hi_nxt = alu_res[CNT_W-1:0];
            clip_nxt   = clip_r | alu_clip;
            state_nxt  = S_FIN;
          end
          default: begin
            step_nxt = C_HL;
          end
        endcase
      end
      S_FIN: begin
        if (!out_vld_r || out_ch.ready) begin
          out_vld_nxt = 1'b1;
          state_nxt   = S_LOAD;
        end
      end
      default: begin
        state_nxt = S_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_LOAD;
      step_r     <= C_HL;
      load_cnt_r <= '0;
      ovf_r      <= 1'b0;
      pend_r     <= 1'b0;
      ph_r       <= 1'b0;
      first_r    <= 1'b0;
      out_vld_r  <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      step_r     <= step_nxt;
      load_cnt_r <= load_cnt_nxt;
      ovf_r      <= ovf_nxt;
      pend_r     <= pend_nxt;
      ph_r       <= ph_nxt;
      first_r    <= first_nxt;
      out_vld_r  <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    n_r       <= n_nxt;
    stat_r    <= stat_nxt;
    addr_r    <= addr_nxt;
    pidx_r    <= pidx_nxt;
    height_r  <= height_nxt;
    peak_r    <= peak_nxt;
    left_r    <= left_nxt;
    right_r   <= right_nxt;
    hl_r      <= hl_nxt;
    hr_r      <= hr_nxt;
    width_r   <= width_nxt;
    tmp_r     <= tmp_nxt;
    core_lo_r <= core_lo_nxt;
    core_hi_r <= core_hi_nxt;
    d_r       <= d_nxt;
    win_lo_r  <= win_lo_nxt;
    win_hi_r  <= win_hi_nxt;
    clip_r    <= clip_nxt;
  end

  // output word register
  logic                  ok;
  logic [CH_W-1:0]       o_chan_r;
  logic [COUNT_BITS-1:0] o_height_r;
  logic [CNT_W-1:0]      o_width_r, o_wlo_r, o_whi_r;
  logic                  o_clip_r;
  spf_pkg::status_t      o_stat_r;

  assign ok = (stat_r == spf_pkg::ST_OK);

  always_ff @(posedge clk) begin
    if ((state_r == S_FIN) && (!out_vld_r || out_ch.ready)) begin
      o_chan_r   <= ok ? peak_r : '0;
      o_height_r <= ok ? height_r : '0;
      o_width_r  <= ok ? width_r : '0;
      o_wlo_r    <= ok ? win_lo_r : '0;
      o_whi_r    <= ok ? win_hi_r : '0;
      o_clip_r   <= ok ? clip_r : 1'b0;
      o_stat_r   <= stat_r;
    end
  end

  assign out_ch.valid          = out_vld_r;
  assign out_ch.peak_channel   = o_chan_r;
  assign out_ch.peak_height    = o_height_r;
  assign out_ch.peak_width     = o_width_r;
  assign out_ch.window_low     = o_wlo_r;
  assign out_ch.window_high    = o_whi_r;
  assign out_ch.window_clipped = o_clip_r;
  assign out_ch.status         = o_stat_r;

endmodule
